[sv/bpc_pkg.sv]
// shared types and constants for the button press classifier
package bpc_pkg;

  localparam int CfgDataW = 8;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_FILTER_TOP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_HOLD_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLD_REWIND     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_RUN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CALIB_THRESHOLD = 3'd4;

  localparam logic [3:0] FILTER_TOP_RST      = 4'd3;
  localparam logic [5:0] LONG_HOLD_COUNT_RST = 6'd50;
  localparam logic [5:0] HOLD_REWIND_RST     = 6'd25;
  localparam logic [2:0] RELEASE_RUN_RST     = 3'd5;
  localparam logic [7:0] CALIB_THRESHOLD_RST = 8'd200;

  localparam logic [1:0] CHECK_ABORT = 2'd2;
  localparam logic [7:0] TICK_MAX    = 8'hFF;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [3:0] filter_top;
    logic [5:0] long_hold_count;
    logic [5:0] hold_rewind;
    logic [2:0] release_run;
    logic [7:0] calib_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0] light_toggles;
    logic       calib_reset;
    logic       press_done;
    logic       filter_stepped;
    logic [3:0] filter_level;
    logic       busy_res;
  } res_t;

endpackage

[sv/button_press_classifier_core.sv]
// button press classifier: input register, classification logic, result register
// an input transfer passes the input register and then the result register to reach the out_ channel
// throughput: one item per cycle while out_stall does not hold the result, set by the state update in bpc_class
// a pending result under out_stall still lets one more item into the input register
// reset (rst_n low, synchronous) empties both registers, clears press state and
// filter level, and loads the configuration registers with their defaults
module button_press_classifier_core import bpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic                in_pressed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_light_toggles,
  output logic                out_calib_reset,
  output logic                out_press_done,
  output logic                out_filter_stepped,
  output logic [3:0]          out_filter_level,
  output logic                out_busy_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic in_valid_r;
  logic cmd_r;
  logic pressed_r;
  logic out_valid_r;
  res_t res_r;
  res_t res;
  logic advance;
  logic step;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_top      <= FILTER_TOP_RST;
      cfg_r.long_hold_count <= LONG_HOLD_COUNT_RST;
      cfg_r.hold_rewind     <= HOLD_REWIND_RST;
      cfg_r.release_run     <= RELEASE_RUN_RST;
      cfg_r.calib_threshold <= CALIB_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_TOP:      cfg_r.filter_top      <= cfg_wdata[3:0];
        REG_LONG_HOLD_COUNT: cfg_r.long_hold_count <= cfg_wdata[5:0];
        REG_HOLD_REWIND:     cfg_r.hold_rewind     <= cfg_wdata[5:0];
        REG_RELEASE_RUN:     cfg_r.release_run     <= cfg_wdata[2:0];
        REG_CALIB_THRESHOLD: cfg_r.calib_threshold <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r     <= in_cmd;
      pressed_r <= in_pressed;
    end
  end

  bpc_class u_class (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cmd     (cmd_r),
    .pressed (pressed_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_light_toggles  = res_r.light_toggles;
  assign out_calib_reset    = res_r.calib_reset;
  assign out_press_done     = res_r.press_done;
  assign out_filter_stepped = res_r.filter_stepped;
  assign out_filter_level   = res_r.filter_level;
  assign out_busy_res       = res_r.busy_res;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held item did not reach the result register");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(cmd_r) && $stable(pressed_r))
    else $error("stalled item lost from the input register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r))
    else $error("pending result changed before transfer");

endmodule

[sv/bpc_class.sv]
// press state and per-sample classification logic
module bpc_class import bpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic cmd,
  input  logic pressed,
  input  cfg_t cfg,
  output res_t res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CHECK = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] check_r, check_nxt;
  logic [2:0] rel_run_r, rel_run_nxt;
  logic [5:0] hold_r, hold_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       long_seen_r, long_seen_nxt;
  logic [3:0] level_r, level_nxt;

  logic [4:0] level_inc;
  logic [3:0] level_step;
  logic [1:0] toggles;
  logic       calib;
  logic       done;
  logic       stepped;

  assign level_inc  = {1'b0, level_r} + 5'd1;
  assign level_step = (level_inc > {1'b0, cfg.filter_top}) ? 4'd0 : level_inc[3:0];

  always_comb begin
    phase_nxt     = phase_r;
    check_nxt     = check_r;
    rel_run_nxt   = rel_run_r;
    hold_nxt      = hold_r;
    ticks_nxt     = ticks_r;
    long_seen_nxt = long_seen_r;
    level_nxt     = level_r;
    toggles       = 2'd0;
    calib         = 1'b0;
    done          = 1'b0;
    stepped       = 1'b0;

    if (cmd == CMD_START) begin
      phase_nxt     = PH_CHECK;
      check_nxt     = pressed ? 2'd0 : 2'd1;
      rel_run_nxt   = 3'd0;
      hold_nxt      = 6'd0;
      ticks_nxt     = 8'd0;
      long_seen_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_CHECK: begin
          if (!pressed) check_nxt = check_r + 2'd1;
          if (check_nxt >= CHECK_ABORT) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            hold_nxt    = {4'd0, check_nxt};
            rel_run_nxt = 3'd0;
            phase_nxt   = PH_HOLD;
            // zero release run ends the press at the passing check itself
            if (cfg.release_run == 3'd0) begin
              if (!long_seen_r) begin
                level_nxt = level_step;
                stepped   = 1'b1;
              end
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
        end
        PH_HOLD: begin
          if (pressed) begin
            rel_run_nxt = 3'd0;
            if (hold_r < cfg.long_hold_count) hold_nxt = hold_r + 6'd1;
            if (hold_nxt == cfg.long_hold_count) begin
              toggles       = 2'd1;
              hold_nxt      = cfg.hold_rewind;
              long_seen_nxt = 1'b1;
            end
            if (ticks_r != TICK_MAX) ticks_nxt = ticks_r + 8'd1;
            if (ticks_nxt > cfg.calib_threshold) begin
              calib   = 1'b1;
              toggles = toggles + 2'd1;
            end
          end else begin
            rel_run_nxt = rel_run_r + 3'd1;
            if (rel_run_nxt >= cfg.release_run) begin
              if (!long_seen_r) begin
                level_nxt = level_step;
                stepped   = 1'b1;
              end
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
        end
        default: begin
          // tick while idle is ignored
        end
      endcase
    end

    res.light_toggles  = toggles;
    res.calib_reset    = calib;
    res.press_done     = done;
    res.filter_stepped = stepped;
    res.filter_level   = level_nxt;
    res.busy_res       = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      check_r     <= 2'd0;
      rel_run_r   <= 3'd0;
      hold_r      <= 6'd0;
      ticks_r     <= 8'd0;
      long_seen_r <= 1'b0;
      level_r     <= 4'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      check_r     <= check_nxt;
      rel_run_r   <= rel_run_nxt;
      hold_r      <= hold_nxt;
      ticks_r     <= ticks_nxt;
      long_seen_r <= long_seen_nxt;
      level_r     <= level_nxt;
    end
  end

  a_check_low: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHECK |-> check_r < CHECK_ABORT)
    else $error("check phase holds an aborting count");

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd == CMD_START |=> phase_r == PH_CHECK)
    else $error("start did not open a press");

  a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.filter_stepped |-> res.press_done && !res.busy_res)
    else $error("filter step outside press end");

  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd == CMD_TICK && phase_r == PH_IDLE |=> $stable(level_r))
    else $error("idle tick changed the filter level");

endmodule

[dv/tb.sv]
// testbench for button_press_classifier_core: directed and random presses checked per sample
`timescale 1ns / 100ps

module tb;
  import bpc_pkg::*;

  localparam int PIPE_LATENCY = 2;
  localparam int IDLE_PCT     = 28;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {PH_IDLE, PH_CHECK, PH_HOLD} press_phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_cmd;
  logic                in_pressed;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_light_toggles;
  logic                out_calib_reset;
  logic                out_press_done;
  logic                out_filter_stepped;
  logic [3:0]          out_filter_level;
  logic                out_busy_res;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  button_press_classifier_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_pressed        (in_pressed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_light_toggles (out_light_toggles),
    .out_calib_reset   (out_calib_reset),
    .out_press_done    (out_press_done),
    .out_filter_stepped(out_filter_stepped),
    .out_filter_level  (out_filter_level),
    .out_busy_res      (out_busy_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // classifier state as predicted
  cfg_t         cfg_now;
  press_phase_t phase_q;
  logic [1:0]   released_checks;
  logic [2:0]   release_cnt;
  logic [5:0]   hold_cnt;
  logic [7:0]   tick_cnt;
  logic         long_seen;
  logic [3:0]   filter_lvl;

  res_t expected_results[$];
  res_t want_res;
  int   error_count = 0;
  int   sent_count  = 0;
  bit   in_idle_en  = 1'b1;
  bit   out_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic end_press();
    logic [4:0] nxt;
    logic       stepped;
    stepped = 1'b0;
    if (!long_seen) begin
      nxt = {1'b0, filter_lvl} + 5'd1;
      if (nxt > {1'b0, cfg_now.filter_top}) nxt = 5'd0;
      filter_lvl = nxt[3:0];
      stepped = 1'b1;
    end
    phase_q = PH_IDLE;
    return stepped;
  endfunction

  function automatic res_t classify_sample(logic cmd, logic pressed);
    res_t r;
    r = '0;
    if (cmd == CMD_START) begin
      phase_q         = PH_CHECK;
      released_checks = pressed ? 2'd0 : 2'd1;
      release_cnt     = 3'd0;
      hold_cnt        = 6'd0;
      tick_cnt        = 8'd0;
      long_seen       = 1'b0;
    end else if (phase_q == PH_CHECK) begin
      if (!pressed) released_checks = released_checks + 2'd1;
      if (released_checks >= CHECK_ABORT) begin
        phase_q = PH_IDLE;
        r.press_done = 1'b1;
      end else begin
        hold_cnt    = {4'd0, released_checks};
        release_cnt = 3'd0;
        phase_q     = PH_HOLD;
        // zero release run closes the press right at the second check
        if (cfg_now.release_run == 3'd0) begin
          r.filter_stepped = end_press();
          r.press_done     = 1'b1;
        end
      end
    end else if (phase_q == PH_HOLD) begin
      if (pressed) begin
        release_cnt = 3'd0;
        if (hold_cnt < cfg_now.long_hold_count) hold_cnt = hold_cnt + 6'd1;
        if (hold_cnt == cfg_now.long_hold_count) begin
          r.light_toggles = r.light_toggles + 2'd1;
          hold_cnt        = cfg_now.hold_rewind;
          long_seen       = 1'b1;
        end
        if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cfg_now.calib_threshold) begin
          r.calib_reset   = 1'b1;
          r.light_toggles = r.light_toggles + 2'd1;
        end
      end else begin
        release_cnt = release_cnt + 3'd1;
        if (release_cnt >= cfg_now.release_run) begin
          r.filter_stepped = end_press();
          r.press_done     = 1'b1;
        end
      end
    end
    r.filter_level = filter_lvl;
    r.busy_res     = (phase_q != PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string field, logic [3:0] got, logic [3:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  // result side: random stall, checked against the oldest prediction
  always @(negedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want_res = expected_results.pop_front();
        compare_field("light_toggles", 4'(out_light_toggles), 4'(want_res.light_toggles));
        compare_field("calib_reset", 4'(out_calib_reset), 4'(want_res.calib_reset));
        compare_field("press_done", 4'(out_press_done), 4'(want_res.press_done));
        compare_field("filter_stepped", 4'(out_filter_stepped),
                      4'(want_res.filter_stepped));
        compare_field("filter_level", out_filter_level, want_res.filter_level);
        compare_field("busy_res", 4'(out_busy_res), 4'(want_res.busy_res));
      end
    end
  end

  // returns in the time step of the accepting edge; valid stays up until the next call
  task automatic send_sample(logic cmd, logic pressed);
    @(negedge clk);
    while (in_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_cmd     = cmd;
    in_pressed = pressed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(classify_sample(cmd, pressed));
    sent_count++;
  endtask

  task automatic wait_results_settled();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FILTER_TOP:      cfg_now.filter_top      = data[3:0];
      REG_LONG_HOLD_COUNT: cfg_now.long_hold_count = data[5:0];
      REG_HOLD_REWIND:     cfg_now.hold_rewind     = data[5:0];
      REG_RELEASE_RUN:     cfg_now.release_run     = data[2:0];
      REG_CALIB_THRESHOLD: cfg_now.calib_threshold = data;
      default: ;
    endcase
  endtask

  task automatic held_press(int held, int released);
    send_sample(CMD_START, 1'b1);
    send_sample(CMD_TICK, 1'b1);
    repeat (held) send_sample(CMD_TICK, 1'b1);
    repeat (released) send_sample(CMD_TICK, 1'b0);
  endtask

  task automatic test_idle_ticks();
    send_sample(CMD_TICK, 1'b0);
    send_sample(CMD_TICK, 1'b1);
    wait_results_settled();
  endtask

  task automatic test_short_press();
    send_sample(CMD_START, 1'b1);
    send_sample(CMD_TICK, 1'b1);
    repeat (3) send_sample(CMD_TICK, 1'b1);
    // broken release run restarts the count
    send_sample(CMD_TICK, 1'b0);
    send_sample(CMD_TICK, 1'b1);
    repeat (5) send_sample(CMD_TICK, 1'b0);
    // new start drops the press in progress
    send_sample(CMD_START, 1'b1);
    send_sample(CMD_TICK, 1'b1);
    send_sample(CMD_START, 1'b0);
    send_sample(CMD_TICK, 1'b1);
    repeat (5) send_sample(CMD_TICK, 1'b0);
    wait_results_settled();
  endtask

  task automatic test_check_abort();
    send_sample(CMD_START, 1'b0);
    send_sample(CMD_TICK, 1'b0);
    send_sample(CMD_START, 1'b1);
    send_sample(CMD_TICK, 1'b0);
    repeat (5) send_sample(CMD_TICK, 1'b0);
    wait_results_settled();
  endtask

  task automatic test_config_extremes();
    set_register(REG_UNUSED, 8'hFF);
    set_register(REG_FILTER_TOP, 8'h00);
    set_register(REG_RELEASE_RUN, 8'h00);
    held_press(0, 0);
    held_press(0, 0);
    wait_results_settled();
    set_register(REG_FILTER_TOP, 8'hFF);
    repeat (17) held_press(0, 0);
    wait_results_settled();
    set_register(REG_RELEASE_RUN, 8'h07);
    held_press(2, 7);
    wait_results_settled();
  endtask

  task automatic test_long_press();
    set_register(REG_LONG_HOLD_COUNT, 8'd2);
    set_register(REG_HOLD_REWIND, 8'd0);
    set_register(REG_CALIB_THRESHOLD, 8'd4);
    set_register(REG_RELEASE_RUN, 8'd1);
    held_press(10, 1);
    wait_results_settled();
    // rewind at or above the threshold: the count stops advancing
    set_register(REG_HOLD_REWIND, 8'd62);
    held_press(6, 1);
    wait_results_settled();
    set_register(REG_LONG_HOLD_COUNT, 8'd0);
    set_register(REG_HOLD_REWIND, 8'd0);
    held_press(4, 1);
    wait_results_settled();
    set_register(REG_LONG_HOLD_COUNT, 8'd1);
    held_press(3, 1);
    wait_results_settled();
  endtask

  task automatic test_tick_saturation();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    set_register(REG_LONG_HOLD_COUNT, 8'd63);
    set_register(REG_HOLD_REWIND, 8'd62);
    set_register(REG_CALIB_THRESHOLD, 8'd254);
    set_register(REG_RELEASE_RUN, 8'd7);
    held_press(262, 7);
    wait_results_settled();
    set_register(REG_CALIB_THRESHOLD, 8'd255);
    held_press(262, 7);
    wait_results_settled();
    set_register(REG_CALIB_THRESHOLD, 8'd0);
    held_press(5, 7);
    wait_results_settled();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic random_press();
    int held;
    held = (cfg_now.long_hold_count > 20) ? $urandom_range(80) : $urandom_range(25);
    send_sample(CMD_START, $urandom_range(9) != 0);
    send_sample(CMD_TICK, $urandom_range(9) != 0);
    repeat (held) send_sample(CMD_TICK, $urandom_range(11) != 0);
    repeat (cfg_now.release_run) send_sample(CMD_TICK, 1'b0);
  endtask

  task automatic test_random_presses();
    int stop_at;
    int phase_end;
    stop_at = sent_count + 1080;
    while (sent_count < stop_at) begin
      wait_results_settled();
      if ($urandom_range(3) == 0) begin
        // full-width register values
        set_register(REG_FILTER_TOP, 8'($urandom_range(255)));
        set_register(REG_LONG_HOLD_COUNT, 8'($urandom_range(255)));
        set_register(REG_HOLD_REWIND, 8'($urandom_range(255)));
        set_register(REG_RELEASE_RUN, 8'($urandom_range(255)));
        set_register(REG_CALIB_THRESHOLD, 8'($urandom_range(255)));
      end else begin
        set_register(REG_FILTER_TOP, 8'($urandom_range(15)));
        set_register(REG_LONG_HOLD_COUNT, 8'($urandom_range(12, 2)));
        set_register(REG_HOLD_REWIND, 8'($urandom_range(12)));
        set_register(REG_RELEASE_RUN, 8'($urandom_range(7, 1)));
        set_register(REG_CALIB_THRESHOLD, 8'($urandom_range(40, 1)));
      end
      phase_end = sent_count + 150;
      while (sent_count < phase_end && sent_count < stop_at) begin
        if ($urandom_range(99) < 80) random_press();
        else repeat ($urandom_range(6, 1))
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    wait_results_settled();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_START;
    in_pressed = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FILTER_TOP;
    cfg_wdata  = '0;
    cfg_now.filter_top      = FILTER_TOP_RST;
    cfg_now.long_hold_count = LONG_HOLD_COUNT_RST;
    cfg_now.hold_rewind     = HOLD_REWIND_RST;
    cfg_now.release_run     = RELEASE_RUN_RST;
    cfg_now.calib_threshold = CALIB_THRESHOLD_RST;
    phase_q         = PH_IDLE;
    released_checks = 2'd0;
    release_cnt     = 3'd0;
    hold_cnt        = 6'd0;
    tick_cnt        = 8'd0;
    long_seen       = 1'b0;
    filter_lvl      = 4'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_ticks();
    test_short_press();
    test_check_abort();
    test_config_extremes();
    test_long_press();
    test_tick_saturation();
    test_random_presses();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/bpc_pkg.sv
sv/bpc_class.sv
sv/button_press_classifier_core.sv
dv/tb.sv
